@@ src/pps_pkg.sv @@
// shared types and constants for the priority process scheduler
// no dependencies; imported by priority_process_scheduler_core
package pps_pkg;

    // table geometry and field widths
    localparam int SLOT_COUNT   = 16;
    localparam int ID_W         = 4;
    localparam int PRIO_W       = 8;
    localparam int OP_W         = 3;
    localparam int CNT_W        = 4;
    localparam int TOP_PRIORITY = 7;
    localparam int COUNT_MAX    = 15;
    localparam int LIMIT_RESET  = 4;

    // event codes
    localparam logic [OP_W-1:0] OP_START    = 3'd0;
    localparam logic [OP_W-1:0] OP_READY    = 3'd1;
    localparam logic [OP_W-1:0] OP_PREEMPT  = 3'd2;
    localparam logic [OP_W-1:0] OP_BLOCK    = 3'd3;
    localparam logic [OP_W-1:0] OP_SCHEDULE = 3'd4;

    // slot state codes
    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_WAITING = 2'd3;

    // one table entry
    typedef struct packed {
        logic [1:0]        st;
        logic [PRIO_W-1:0] prio;
    } t_slot;

    // one result item
    typedef struct packed {
        logic            status;
        logic [ID_W-1:0] picked_id;
        logic            none_ready;
    } t_result;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MODIFY = 5'b00010,
        S_SCAN   = 5'b00100,
        S_PICK   = 5'b01000,
        S_HOLD   = 5'b10000
    } t_fsm;

endpackage

@@ src/priority_process_scheduler_core.sv @@
// priority process scheduler: slot table in a one-port-read, one-port-write memory
// depends on pps_pkg
//
// sequence: a slot event reads its slot at accept, then updates it and forms the result
// in S_MODIFY; a schedule does one memory read per slot in S_SCAN, then picks and writes in S_PICK
// throughput: no new item is taken until the sequencer is back in S_IDLE; a schedule is
// held back by the scan through the single read port of the slot table
// an item is taken while the previous result still waits in the output register
// reset: synchronous, active low; all slots read as unused with priority zero
// (per-entry valid flops), no last pick, repeat count zero, repeat_limit 4
module priority_process_scheduler_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [pps_pkg::OP_W-1:0]  i_operation,
    input  logic [pps_pkg::ID_W-1:0]  i_process_id,
    input  logic [pps_pkg::PRIO_W-1:0] i_priority_req,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_status,
    output logic [pps_pkg::ID_W-1:0]  o_picked_id,
    output logic                      o_none_ready,
    input  logic                      i_cfg_wr_en,
    input  logic [pps_pkg::CNT_W-1:0] i_cfg_wr_data
);
    import pps_pkg::*;

    // slot table memory and per-entry valid flops
    t_slot                 r_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_vld;
    t_slot                 r_rd_data;
    logic                  r_rd_vld;

    // control and item registers
    t_fsm              r_fsm, n_fsm;
    logic [OP_W-1:0]   r_op;
    logic [ID_W-1:0]   r_id;
    logic [PRIO_W-1:0] r_prio;
    logic [ID_W-1:0]   r_idx, n_idx;

    // scan trackers: best over all slots and best excluding the last pick
    logic              r_fnd_all, n_fnd_all;
    logic [ID_W-1:0]   r_id_all, n_id_all;
    logic [PRIO_W-1:0] r_pr_all, n_pr_all;
    logic              r_fnd_ex, n_fnd_ex;
    logic [ID_W-1:0]   r_id_ex, n_id_ex;
    logic [PRIO_W-1:0] r_pr_ex, n_pr_ex;
    logic              r_last_rdy, n_last_rdy;

    // scheduler history and config
    logic              r_last_vld, n_last_vld;
    logic [ID_W-1:0]   r_last_id, n_last_id;
    logic [CNT_W-1:0]  r_rep_cnt, n_rep_cnt;
    logic [CNT_W-1:0]  r_limit;

    // result path
    t_result           r_out, n_out;
    logic              r_out_valid, n_out_valid;
    t_result           r_pend, n_pend;

    // memory access controls
    logic              accept;
    logic              rd_en;
    logic [ID_W-1:0]   rd_addr;
    logic              wr_en;
    logic [ID_W-1:0]   wr_addr;
    t_slot             wr_data;
    t_slot             rd_slot;
    t_result           res;
    logic              res_vld;
    logic              out_free;
    logic              skip;
    logic              sel_fnd;
    logic [ID_W-1:0]   sel_id;
    logic [PRIO_W-1:0] sel_prio;
    logic              bad_req;

    assign accept   = i_in_valid && (r_fsm == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // entry never written reads as unused, priority zero
    always_comb begin
        rd_slot = r_rd_data;
        if (!r_rd_vld) begin
            rd_slot = '{st: ST_UNUSED, prio: '0};
        end
    end

    // read address: event slot or first slot at accept, next slot during scan
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = i_process_id;
        if (accept) begin
            rd_en = 1'b1;
            if (i_operation == OP_SCHEDULE) begin
                rd_addr = '0;
            end
        end else if (r_fsm == S_SCAN) begin
            rd_en   = (r_idx != ID_W'(SLOT_COUNT - 1));
            rd_addr = r_idx + 1'b1;
        end
    end

    // skip test and final choice
    always_comb begin
        skip     = r_last_vld && (r_rep_cnt >= r_limit) && r_last_rdy;
        sel_fnd  = skip ? r_fnd_ex : r_fnd_all;
        sel_id   = skip ? r_id_ex  : r_id_all;
        sel_prio = skip ? r_pr_ex  : r_pr_all;
        bad_req  = (r_op > OP_SCHEDULE) ||
                   ((ID_W+1)'(r_id) >= (ID_W+1)'(SLOT_COUNT));
    end

    // sequencer, scan and result logic
    always_comb begin
        n_fsm      = r_fsm;
        n_idx      = r_idx;
        n_fnd_all  = r_fnd_all;
        n_id_all   = r_id_all;
        n_pr_all   = r_pr_all;
        n_fnd_ex   = r_fnd_ex;
        n_id_ex    = r_id_ex;
        n_pr_ex    = r_pr_ex;
        n_last_rdy = r_last_rdy;
        n_last_vld = r_last_vld;
        n_last_id  = r_last_id;
        n_rep_cnt  = r_rep_cnt;
        n_pend     = r_pend;
        wr_en      = 1'b0;
        wr_addr    = r_id;
        wr_data    = rd_slot;
        res        = '0;
        res_vld    = 1'b0;

        unique case (r_fsm)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_SCHEDULE) begin
                        n_fsm      = S_SCAN;
                        n_idx      = '0;
                        n_fnd_all  = 1'b0;
                        n_fnd_ex   = 1'b0;
                        n_last_rdy = 1'b0;
                    end else begin
                        n_fsm = S_MODIFY;
                    end
                end
            end
            S_MODIFY: begin
                res_vld    = 1'b1;
                res.status = 1'b1;
                if (!bad_req) begin
                    unique case (r_op)
                        OP_START: begin
                            if (rd_slot.st == ST_UNUSED &&
                                r_prio <= PRIO_W'(TOP_PRIORITY)) begin
                                wr_en      = 1'b1;
                                wr_data    = '{st: ST_WAITING, prio: r_prio};
                                res.status = 1'b0;
                            end
                        end
                        OP_READY: begin
                            if (rd_slot.st == ST_WAITING || rd_slot.st == ST_UNUSED) begin
                                wr_en      = 1'b1;
                                wr_data.st = ST_READY;
                                res.status = 1'b0;
                            end
                        end
                        OP_PREEMPT: begin
                            if (rd_slot.st == ST_RUNNING) begin
                                wr_en      = 1'b1;
                                wr_data.st = ST_READY;
                                res.status = 1'b0;
                            end
                        end
                        default: begin
                            if (rd_slot.st == ST_RUNNING) begin
                                wr_en      = 1'b1;
                                wr_data.st = ST_WAITING;
                                res.status = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // slot r_idx is on the read port this cycle
                if (rd_slot.st == ST_READY) begin
                    if (!r_fnd_all || rd_slot.prio > r_pr_all) begin
                        n_fnd_all = 1'b1;
                        n_id_all  = r_idx;
                        n_pr_all  = rd_slot.prio;
                    end
                    if (r_last_vld && r_idx == r_last_id) begin
                        n_last_rdy = 1'b1;
                    end else if (!r_fnd_ex || rd_slot.prio > r_pr_ex) begin
                        n_fnd_ex = 1'b1;
                        n_id_ex  = r_idx;
                        n_pr_ex  = rd_slot.prio;
                    end
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == ID_W'(SLOT_COUNT - 1)) begin
                    n_fsm = S_PICK;
                end
            end
            S_PICK: begin
                res_vld = 1'b1;
                if (sel_fnd) begin
                    wr_en         = 1'b1;
                    wr_addr       = sel_id;
                    wr_data       = '{st: ST_RUNNING, prio: sel_prio};
                    res.picked_id = sel_id;
                    if (r_last_vld && sel_id == r_last_id) begin
                        if (r_rep_cnt != CNT_W'(COUNT_MAX)) begin
                            n_rep_cnt = r_rep_cnt + 1'b1;
                        end
                    end else begin
                        n_rep_cnt = '0;
                    end
                    n_last_vld = 1'b1;
                    n_last_id  = sel_id;
                end else begin
                    res.none_ready = 1'b1;
                    n_last_vld     = 1'b0;
                    n_rep_cnt      = '0;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_fsm = S_IDLE;
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase

        // finished result: straight to output if free, else park it
        if (res_vld) begin
            n_pend = res;
            n_fsm  = out_free ? S_IDLE : S_HOLD;
        end
    end

    // output register
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (res_vld && out_free) begin
            n_out       = res;
            n_out_valid = 1'b1;
        end else if (r_fsm == S_HOLD && out_free) begin
            n_out       = r_pend;
            n_out_valid = 1'b1;
        end
    end

    // slot table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // valid flops and read-valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_vld[rd_addr];
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_last_vld  <= 1'b0;
            r_rep_cnt   <= '0;
            r_limit     <= CNT_W'(LIMIT_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_last_vld  <= n_last_vld;
            r_rep_cnt   <= n_rep_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_id   <= i_process_id;
            r_prio <= i_priority_req;
        end
        r_idx      <= n_idx;
        r_fnd_all  <= n_fnd_all;
        r_id_all   <= n_id_all;
        r_pr_all   <= n_pr_all;
        r_fnd_ex   <= n_fnd_ex;
        r_id_ex    <= n_id_ex;
        r_pr_ex    <= n_pr_ex;
        r_last_rdy <= n_last_rdy;
        r_last_id  <= n_last_id;
        r_pend     <= n_pend;
        r_out      <= n_out;
    end

    // ports
    assign o_in_stall   = (r_fsm != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_picked_id  = r_out.picked_id;
    assign o_none_ready = r_out.none_ready;

endmodule
